// File: hdl/bfsh_pkg.sv
// Shared types and constants for the string-hash Bloom filter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package bfsh_pkg;

	localparam int unsigned HASH_W = 64;
	localparam int unsigned KEY_W  = 8;
	localparam int unsigned IDX_W  = 17;   // filter bit index, also bit_count width
	localparam int unsigned BIT_W  = 5;    // bit within a 32-bit store word

	localparam logic [HASH_W-1:0] RS_START        = 64'd63689;
	localparam logic [31:0]       RS_STEP         = 32'd378551;
	localparam logic [IDX_W-1:0]  BIT_COUNT_RESET = 17'h10000;

	// request func field
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_QUERY  = 1'b1;

	// controller -> datapath commands
	typedef struct packed {
		logic capture;     // take a byte, launch the partial products
		logic update;      // fold partial products into the hashes
		logic clear_hash;  // key end: restart hashes
		logic mod_load;    // key end: load both hashes into the reducer
		logic mod_step;    // one remainder bit step
		logic rd_en;       // read the store word of the selected index
		logic wr_en;       // write back that word with the index bit set
		logic sel_b;       // 0: index from simple hash, 1: from running hash
		logic clr_en;      // clear one store word
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic mod_done;
		logic bit_hit;
		logic clr_last;
	} sts_t;

endpackage

// File: hdl/bfsh_ctrl.sv
// Sequencer for the Bloom filter: byte hashing, reduction, store access.
// Depends on bfsh_pkg (cmd_t, sts_t, func codes).
`timescale 1ns / 1ps

module bfsh_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           func,
	input  logic           last,
	input  bfsh_pkg::sts_t sts,
	output bfsh_pkg::cmd_t cmd,
	output logic           busy,
	output logic           done,
	output logic           present
);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_ADD   = 4'd2;
	localparam logic [3:0] S_MOD   = 4'd3;
	localparam logic [3:0] S_RDA   = 4'd4;
	localparam logic [3:0] S_WRA   = 4'd5;
	localparam logic [3:0] S_RDB   = 4'd6;
	localparam logic [3:0] S_WRB   = 4'd7;
	localparam logic [3:0] S_CHK   = 4'd8;

	logic [3:0] state_q, state_d;
	logic       func_q, last_q, hit_a_q;
	logic       done_q, present_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_ADD;
				end
			end
			S_ADD: begin
				cmd.update = 1'b1;
				if (last_q) begin
					cmd.clear_hash = 1'b1;
					cmd.mod_load   = 1'b1;
					state_d        = S_MOD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_MOD: begin
				if (sts.mod_done) state_d = S_RDA;
				else cmd.mod_step = 1'b1;
			end
			S_RDA: begin
				cmd.rd_en = 1'b1;
				state_d   = (func_q == bfsh_pkg::FUNC_QUERY) ? S_RDB : S_WRA;
			end
			S_WRA: begin
				cmd.wr_en = 1'b1;
				state_d   = S_RDB;
			end
			S_RDB: begin
				cmd.rd_en = 1'b1;
				cmd.sel_b = 1'b1;
				state_d   = (func_q == bfsh_pkg::FUNC_QUERY) ? S_CHK : S_WRB;
			end
			S_WRB: begin
				cmd.wr_en = 1'b1;
				cmd.sel_b = 1'b1;
				state_d   = S_IDLE;
			end
			S_CHK: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			func_q    <= 1'b0;
			last_q    <= 1'b0;
			hit_a_q   <= 1'b0;
			done_q    <= 1'b0;
			present_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.capture) begin
				func_q <= func;
				last_q <= last;
			end
			// first index result is on the read port while the second is fetched
			if (state_q == S_RDB) hit_a_q <= sts.bit_hit;
			done_q    <= (state_q == S_CHK);
			present_q <= (state_q == S_CHK) && hit_a_q && sts.bit_hit;
		end
	end

	assign busy    = (state_q != S_IDLE);
	assign done    = done_q;
	assign present = present_q;

	a_done_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_CHK))
		else $error("result strobe without a completed check");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> ($past(cmd.rd_en) && ($past(cmd.sel_b) == cmd.sel_b)))
		else $error("store write without a read of the same index");

	a_step_until_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mod_step |-> !sts.mod_done)
		else $error("reducer stepped past its last bit");

endmodule

// File: hdl/bfsh_hash.sv
// Hash datapath: multiply-by-131 hash and running-multiplier hash, 64-bit wrap.
// Depends on bfsh_pkg (cmd_t, constants).
`timescale 1ns / 1ps

module bfsh_hash (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bfsh_pkg::cmd_t                cmd,
	input  logic [bfsh_pkg::KEY_W-1:0]    key_byte,
	output logic [bfsh_pkg::HASH_W-1:0]   hs_next,
	output logic [bfsh_pkg::HASH_W-1:0]   hr_next
);

	logic [bfsh_pkg::HASH_W-1:0] hs_q, hr_q, m_q;
	logic [bfsh_pkg::KEY_W-1:0]  kb_s1;

	// partial products, one 32-bit multiplier each
	logic [63:0] p_ll, p_ll_s1, q_l, q_l_s1;
	logic [31:0] p_hl, p_lh, q_h, p_hl_s1, p_lh_s1, q_h_s1;
	logic [31:0] cross_sum;
	logic [bfsh_pkg::HASH_W-1:0] ch, m_next;

	assign p_ll = 64'(hr_q[31:0]) * 64'(m_q[31:0]);
	assign p_hl = hr_q[63:32] * m_q[31:0];
	assign p_lh = hr_q[31:0]  * m_q[63:32];
	assign q_l  = 64'(m_q[31:0]) * 64'(bfsh_pkg::RS_STEP);
	assign q_h  = m_q[63:32]  * bfsh_pkg::RS_STEP;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kb_s1   <= key_byte;
			p_ll_s1 <= p_ll;
			p_hl_s1 <= p_hl;
			p_lh_s1 <= p_lh;
			q_l_s1  <= q_l;
			q_h_s1  <= q_h;
		end
	end

	assign ch        = {{(bfsh_pkg::HASH_W-bfsh_pkg::KEY_W){kb_s1[bfsh_pkg::KEY_W-1]}}, kb_s1};
	assign cross_sum = p_hl_s1 + p_lh_s1;
	// x*131 = x*128 + x*2 + x
	assign hs_next   = (hs_q << 7) + (hs_q << 1) + hs_q + ch;
	assign hr_next   = p_ll_s1 + {cross_sum, 32'd0} + ch;
	assign m_next    = q_l_s1 + {q_h_s1, 32'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_q <= '0;
			hr_q <= '0;
			m_q  <= bfsh_pkg::RS_START;
		end else if (cmd.update) begin
			if (cmd.clear_hash) begin
				hs_q <= '0;
				hr_q <= '0;
				m_q  <= bfsh_pkg::RS_START;
			end else begin
				hs_q <= hs_next;
				hr_q <= hr_next;
				m_q  <= m_next;
			end
		end
	end

endmodule

// File: hdl/bfsh_mod.sv
// Bit-serial reduction of both hashes modulo the effective filter size.
// Depends on bfsh_pkg (cmd_t, widths).
`timescale 1ns / 1ps

module bfsh_mod #(
	parameter int unsigned NUM_WORDS = 2048
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bfsh_pkg::cmd_t               cmd,
	input  logic [bfsh_pkg::IDX_W-1:0]   bit_count,
	input  logic [bfsh_pkg::HASH_W-1:0]  hs_in,
	input  logic [bfsh_pkg::HASH_W-1:0]  hr_in,
	output logic [bfsh_pkg::IDX_W-1:0]   idx_a,
	output logic [bfsh_pkg::IDX_W-1:0]   idx_b,
	output logic                         mod_done
);

	localparam int unsigned IW   = bfsh_pkg::IDX_W;
	localparam int unsigned HW   = bfsh_pkg::HASH_W;
	localparam int unsigned CW   = $clog2(HW + 1);
	localparam logic [31:0] CAP  = 32'(NUM_WORDS) * 32'd32;

	logic [HW-1:0] a_q, b_q;
	logic [IW-1:0] ra_q, rb_q, n_q, n_eff;
	logic [CW-1:0] cnt_q;
	logic [IW:0]   ta, tb;

	always_comb begin
		n_eff = bit_count;
		if (bit_count == '0) n_eff = {{(IW-1){1'b0}}, 1'b1};
		else if (32'(bit_count) > CAP) n_eff = CAP[IW-1:0];
	end

	// restoring remainder step: shift in one dividend bit, subtract once
	assign ta = {ra_q, a_q[HW-1]};
	assign tb = {rb_q, b_q[HW-1]};

	always_ff @(posedge clk) begin
		if (cmd.mod_load) begin
			a_q  <= hs_in;
			b_q  <= hr_in;
			ra_q <= '0;
			rb_q <= '0;
			n_q  <= n_eff;
		end else if (cmd.mod_step) begin
			a_q  <= a_q << 1;
			b_q  <= b_q << 1;
			ra_q <= (ta >= {1'b0, n_q}) ? IW'(ta - {1'b0, n_q}) : ta[IW-1:0];
			rb_q <= (tb >= {1'b0, n_q}) ? IW'(tb - {1'b0, n_q}) : tb[IW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (cmd.mod_load) cnt_q <= '0;
		else if (cmd.mod_step) cnt_q <= cnt_q + 1'b1;
	end

	assign mod_done = (cnt_q == CW'(HW));
	assign idx_a    = ra_q;
	assign idx_b    = rb_q;

endmodule

// File: hdl/bfsh_store.sv
// Filter bit store: NUM_WORDS x 32 memory, read-modify-write, reset sweep.
// Depends on bfsh_pkg (cmd_t, widths).
`timescale 1ns / 1ps

module bfsh_store #(
	parameter int unsigned NUM_WORDS = 2048
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bfsh_pkg::cmd_t              cmd,
	input  logic [bfsh_pkg::IDX_W-1:0]  idx_a,
	input  logic [bfsh_pkg::IDX_W-1:0]  idx_b,
	output logic                        bit_hit,
	output logic                        clr_last
);

	localparam int unsigned AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int unsigned IW = bfsh_pkg::IDX_W;
	localparam int unsigned BW = bfsh_pkg::BIT_W;
	localparam int unsigned WW = IW - BW;

	logic [31:0]         mem [NUM_WORDS];
	logic [31:0]         rdata_q;
	logic [BW-1:0]       bit_q;
	logic [AW-1:0]       clr_q, addr, waddr;
	logic [IW-1:0]       idx;
	logic [AW+WW-1:0]    word_ext;
	logic [31:0]         wdata;

	assign idx      = cmd.sel_b ? idx_b : idx_a;
	// index < effective size <= NUM_WORDS*32, so the word number fits AW
	assign word_ext = {{AW{1'b0}}, idx[IW-1:BW]};
	assign addr     = word_ext[AW-1:0];
	assign waddr    = cmd.clr_en ? clr_q : addr;
	assign wdata    = cmd.clr_en ? 32'd0 : (rdata_q | (32'd1 << bit_q));

	always_ff @(posedge clk) begin
		if (cmd.clr_en || cmd.wr_en) mem[waddr] <= wdata;
		if (cmd.rd_en) begin
			rdata_q <= mem[addr];
			bit_q   <= idx[BW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clr_en) clr_q <= clr_q + 1'b1;
	end

	assign clr_last = (clr_q == AW'(NUM_WORDS - 1));
	assign bit_hit  = rdata_q[bit_q];

endmodule

// File: hdl/bloom_filter_string_hash_top.sv
// Bloom filter over byte-streamed string keys: each key byte is captured, then folded into the
// hashes, busy meanwhile; done strobes only after a query's last byte, never after an insert.
// Last byte: hash add, 64 reducer steps, store accesses, then on a query a done check; no output stall.
// After reset a sweep clears the NUM_WORDS-word bit store, one word a cycle, busy meanwhile.
// Depends on bfsh_pkg, bfsh_ctrl, bfsh_hash, bfsh_mod, bfsh_store.
`timescale 1ns / 1ps

module bloom_filter_string_hash_top #(
	parameter int unsigned NUM_WORDS = 2048
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// key byte request
	input  logic                        start,
	output logic                        busy,
	input  logic                        func,
	input  logic [bfsh_pkg::KEY_W-1:0]  key_byte,
	input  logic                        last,
	// query result
	output logic                        done,
	output logic                        present,
	// bit_count register write
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bfsh_pkg::IDX_W-1:0]  cfg_data
);

	bfsh_pkg::cmd_t cmd;
	bfsh_pkg::sts_t sts;

	logic [bfsh_pkg::IDX_W-1:0]  bit_count_q;
	logic [bfsh_pkg::HASH_W-1:0] hs_next, hr_next;
	logic [bfsh_pkg::IDX_W-1:0]  idx_a, idx_b;

	// The register is to be written only between keys; the block does not enforce this, so it is always ready.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bit_count_q <= bfsh_pkg::BIT_COUNT_RESET;
		else if (cfg_valid && cfg_ready) bit_count_q <= cfg_data;
	end

	// Controller: clear sweep, per-byte two-step hash, reduce, store access.
	bfsh_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.func    (func),
		.last    (last),
		.sts     (sts),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done),
		.present (present)
	);

	// Hashes: partial products launched on the request, summed next cycle.
	bfsh_hash u_hash (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.key_byte (key_byte),
		.hs_next  (hs_next),
		.hr_next  (hr_next)
	);

	// Reducer: both hashes taken mod the effective size in parallel, one bit a cycle.
	// Only two indices are formed, one per hash.
	bfsh_mod #(
		.NUM_WORDS (NUM_WORDS)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.bit_count (bit_count_q),
		.hs_in     (hs_next),
		.hr_in     (hr_next),
		.idx_a     (idx_a),
		.idx_b     (idx_b),
		.mod_done  (sts.mod_done)
	);

	// Bit store: read then write back per index on insert, two reads on query.
	bfsh_store #(
		.NUM_WORDS (NUM_WORDS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.idx_a    (idx_a),
		.idx_b    (idx_b),
		.bit_hit  (sts.bit_hit),
		.clr_last (sts.clr_last)
	);

endmodule
